// ----- hw/rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the strict-priority packet queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int MAX_SEND = 64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RX_WRITE,
    ST_THIN_READ,
    ST_THIN_MOVE,
    ST_THIN_DONE,
    ST_TX_SCAN,
    ST_TX_READ,
    ST_TX_EMIT,
    ST_TX_EMPTY
  } spq_state_t;

  // controller to datapath
  typedef struct packed {
    logic load_req;      // capture the input request
    logic rx_write;      // write the new handle into its ring
    logic thin_start;    // clear the walk counters
    logic thin_read;     // read ring entry at the walk index
    logic thin_move;     // copy a kept entry down
    logic thin_done;     // commit the new length
    logic tx_read;       // read oldest entry of the selected level
    logic tx_pop;        // remove it, count it
    logic out_load;      // load output register with a handle
    logic out_empty;     // load output register with an empty result
  } spq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_send;
    logic over_limit;    // level length after append exceeds the limit
    logic walk_end;      // thinning walk finished
    logic any_pending;   // some level is non-empty
    logic send_budget;   // more handles may be sent
    logic sent_any;      // this request has sent a handle
    logic out_busy;      // output register full and not taken
  } spq_stat_t;

endpackage

// ----- hw/rtl/spq_if.sv -----
// ----------------------------------------------------------------------------
// spq_in_if / spq_out_if
// Valid/ready channels of the request and result sides.
// ----------------------------------------------------------------------------
interface spq_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [2:0]  priority_req;
  logic [15:0] packet_handle;
  logic [6:0]  send_limit;
  modport source (output valid, req_type, priority_req, packet_handle, send_limit,
                  input ready);
  modport sink (input valid, req_type, priority_req, packet_handle, send_limit,
                output ready);
endinterface

interface spq_out_if;
  logic        valid;
  logic        ready;
  logic        sent;
  logic [15:0] out_handle;
  logic [2:0]  out_priority;
  logic        last;
  modport source (output valid, sent, out_handle, out_priority, last, input ready);
  modport sink (input valid, sent, out_handle, out_priority, last, output ready);
endinterface

// ----- hw/rtl/strict_priority_packet_queue_top.sv -----
// ----------------------------------------------------------------------------
// strict_priority_packet_queue_top
// Per-level handle FIFOs served in strict priority order.
// ----------------------------------------------------------------------------
// A receive request is accepted and then written; when the level overflows,
// thinning reads each handle, moves the kept ones (a walk over one ring memory
// port) and then commits the new length. A send request is accepted, decoded
// and scanned; each handle sent takes a scan, a memory read and an emit, and
// one that sends nothing gives an empty result. A stall holds scan and emit.
module strict_priority_packet_queue_top
  import spq_pkg::*;
#(
  parameter int NUM_LEVELS  = 8,
  parameter int QUEUE_LIMIT = 16,
  parameter int HANDLE_BITS = 16
) (
  input logic       clk,
  input logic       rst,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);

  spq_cmd_t  cmd;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  spq_datapath #(
    .NUM_LEVELS  (NUM_LEVELS),
    .QUEUE_LIMIT (QUEUE_LIMIT),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule

// ----- hw/rtl/spq_ctrl.sv -----
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer for receive, thinning and send requests.
// ----------------------------------------------------------------------------
module spq_ctrl
  import spq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  spq_stat_t stat,
  output spq_cmd_t  cmd
);

  spq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_valid) state_next = ST_RX_WRITE;
      ST_RX_WRITE: begin
        if (stat.is_send)         state_next = ST_TX_SCAN;
        else if (stat.over_limit) state_next = ST_THIN_READ;
        else                      state_next = ST_IDLE;
      end
      ST_THIN_READ: state_next = stat.walk_end ? ST_THIN_DONE : ST_THIN_MOVE;
      ST_THIN_MOVE: state_next = ST_THIN_READ;
      ST_THIN_DONE: state_next = ST_IDLE;
      ST_TX_SCAN: begin
        if (!stat.out_busy) begin
          if (stat.send_budget && stat.any_pending) state_next = ST_TX_READ;
          else if (stat.sent_any)                   state_next = ST_IDLE;
          else                                      state_next = ST_TX_EMPTY;
        end
      end
      ST_TX_READ:   state_next = ST_TX_EMIT;
      ST_TX_EMIT:   if (!stat.out_busy) state_next = ST_TX_SCAN;
      ST_TX_EMPTY:  state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
      end
      ST_RX_WRITE: begin
        cmd.rx_write   = !stat.is_send;
        cmd.thin_start = 1'b1;
      end
      ST_THIN_READ: cmd.thin_read = !stat.walk_end;
      ST_THIN_MOVE: cmd.thin_move = 1'b1;
      ST_THIN_DONE: cmd.thin_done = 1'b1;
      ST_TX_SCAN:   cmd.tx_read = !stat.out_busy && stat.send_budget && stat.any_pending;
      ST_TX_READ:   ;
      ST_TX_EMIT: begin
        cmd.out_load = !stat.out_busy;
        cmd.tx_pop   = !stat.out_busy;
      end
      ST_TX_EMPTY:  cmd.out_empty = 1'b1;
      default:      ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_TX_EMIT && !stat.out_busy) |=> state == ST_TX_SCAN)
    else $error("emit did not return to scan");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_THIN_MOVE) |=> state == ST_THIN_READ)
    else $error("thin walk broke");
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == ST_IDLE)
    else $error("ready outside idle");

endmodule

// ----- hw/rtl/spq_datapath.sv -----
// ----------------------------------------------------------------------------
// spq_datapath
// Handle rings, per-level length and head pointers, output register.
// ----------------------------------------------------------------------------
module spq_datapath
  import spq_pkg::*;
#(
  parameter int NUM_LEVELS  = 8,
  parameter int QUEUE_LIMIT = 16,
  parameter int HANDLE_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch,
  input  spq_cmd_t  cmd,
  output spq_stat_t stat
);

  localparam int RING   = QUEUE_LIMIT + 1;
  localparam int LW     = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int PW     = $clog2(RING);
  localparam int NW     = $clog2(RING + 1);
  localparam int DEPTH  = NUM_LEVELS * RING;
  localparam int AW     = $clog2(DEPTH);

  logic [HANDLE_BITS-1:0] mem [DEPTH];
  logic [HANDLE_BITS-1:0] rd_data;

  logic [NW-1:0] len  [NUM_LEVELS];
  logic [PW-1:0] head [NUM_LEVELS];

  logic                   req_send;
  logic [LW-1:0]          req_lvl;
  logic [HANDLE_BITS-1:0] req_handle;
  logic [6:0]             budget;
  logic [NW-1:0]          walk_i;
  logic [NW-1:0]          keep_cnt;
  logic [NW-1:0]          walk_n;
  logic [LW-1:0]          top_lvl;
  logic                   top_any;
  logic [LW-1:0]          tx_lvl;

  logic                   ov;
  logic                   ov_sent, ov_last;
  logic [15:0]            ov_handle;
  logic [2:0]             ov_prio;

  // ring slot = (base + off) mod RING, off < RING so one subtract
  function automatic logic [PW-1:0] slot(input logic [PW-1:0] base,
                                         input logic [NW-1:0] off);
    logic [PW:0] s;
    s = {1'b0, base} + (PW+1)'(off);
    if (s >= (PW+1)'(RING)) s = s - (PW+1)'(RING);
    return s[PW-1:0];
  endfunction

  function automatic logic [AW-1:0] addr(input logic [LW-1:0] l, input logic [PW-1:0] p);
    return AW'(l) * AW'(RING) + AW'(p);
  endfunction

  // highest non-empty level
  always_comb begin
    top_lvl = '0;
    top_any = 1'b0;
    for (int k = 0; k < NUM_LEVELS; k++) begin
      if (len[k] != '0) begin
        top_lvl = LW'(k);
        top_any = 1'b1;
      end
    end
  end

  logic [NW-1:0] app_n;
  assign app_n = (len[req_lvl] >= NW'(RING)) ? NW'(RING - 1) : len[req_lvl];

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_send   <= in_ch.req_type;
      if (32'(in_ch.priority_req) >= NUM_LEVELS) req_lvl <= LW'(NUM_LEVELS - 1);
      else                                       req_lvl <= LW'(in_ch.priority_req);
      req_handle <= HANDLE_BITS'(in_ch.packet_handle);
      budget     <= (in_ch.send_limit > 7'(MAX_SEND)) ? 7'(MAX_SEND) : in_ch.send_limit;
    end
    if (cmd.rx_write) begin
      mem[addr(req_lvl, slot(head[req_lvl], app_n))] <= req_handle;
      walk_n <= app_n + NW'(1);
    end
    if (cmd.thin_start) begin
      walk_i   <= '0;
      keep_cnt <= '0;
    end
    if (cmd.thin_read) rd_data <= mem[addr(req_lvl, slot(head[req_lvl], walk_i))];
    if (cmd.thin_move) begin
      // keep entries at even distance from the newest
      if (((walk_n - NW'(1) - walk_i) & NW'(1)) == '0) begin
        mem[addr(req_lvl, slot(head[req_lvl], keep_cnt))] <= rd_data;
        keep_cnt <= keep_cnt + NW'(1);
      end
      walk_i <= walk_i + NW'(1);
    end
    if (cmd.tx_read) begin
      rd_data <= mem[addr(top_lvl, head[top_lvl])];
      tx_lvl  <= top_lvl;
    end
    if (cmd.tx_pop) budget <= budget - 7'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_LEVELS; k++) begin
        len[k]  <= '0;
        head[k] <= '0;
      end
    end else begin
      if (cmd.rx_write) len[req_lvl] <= app_n + NW'(1);
      if (cmd.thin_done) len[req_lvl] <= keep_cnt;
      if (cmd.tx_pop) begin
        len[tx_lvl]  <= len[tx_lvl] - NW'(1);
        head[tx_lvl] <= slot(head[tx_lvl], NW'(1));
      end
    end
  end

  // last handle: budget runs out or every queue will be empty
  logic pop_last;
  always_comb begin
    pop_last = (budget == 7'd1);
    if (len[tx_lvl] == NW'(1)) begin
      pop_last = 1'b1;
      for (int k = 0; k < NUM_LEVELS; k++)
        if (LW'(k) != tx_lvl && len[k] != '0) pop_last = pop_last & 1'b0;
      if (budget == 7'd1) pop_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else if (cmd.out_load || cmd.out_empty) ov <= 1'b1;
    else if (out_ch.ready) ov <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ov_sent   <= 1'b1;
      ov_handle <= 16'(rd_data);
      ov_prio   <= 3'(tx_lvl);
      ov_last   <= pop_last;
    end else if (cmd.out_empty) begin
      ov_sent   <= 1'b0;
      ov_handle <= '0;
      ov_prio   <= '0;
      ov_last   <= 1'b1;
    end
  end

  assign out_ch.valid        = ov;
  assign out_ch.sent         = ov_sent;
  assign out_ch.out_handle   = ov_handle;
  assign out_ch.out_priority = ov_prio;
  assign out_ch.last         = ov_last;

  // empty result only when nothing was sent in this request
  logic sent_any;
  always_ff @(posedge clk) begin
    if (cmd.load_req) sent_any <= 1'b0;
    else if (cmd.tx_pop) sent_any <= 1'b1;
  end

  assign stat.is_send     = req_send;
  assign stat.over_limit  = (app_n + NW'(1)) > NW'(QUEUE_LIMIT);
  assign stat.walk_end    = walk_i == walk_n;
  // after the last handle the scan stops instead of giving an empty result
  assign stat.any_pending = top_any;
  assign stat.send_budget = budget != 7'd0;
  assign stat.sent_any    = sent_any;
  assign stat.out_busy    = ov && !out_ch.ready;

endmodule

// ----- sim/strict_priority_packet_queue_top_test.sv -----
// ----------------------------------------------------------------------------
// strict_priority_packet_queue_top_test
// Drives receive and send requests into the priority queue with random idle
// and stall gaps, predicts every result from a local queue model and checks
// all fields of each one together.
// ----------------------------------------------------------------------------
module strict_priority_packet_queue_top_test
  import spq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEVELS = 8;
  localparam int LIMIT  = 16;
  localparam bit REQ_RECEIVE = 1'b0;
  localparam bit REQ_SEND    = 1'b1;

  typedef struct packed {
    logic        sent;
    logic [15:0] handle;
    logic [2:0]  prio;
    logic        last;
  } spq_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  strict_priority_packet_queue_top u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state: one FIFO of handles per level
  logic [15:0]  level_fifo [LEVELS][$];
  spq_result_t  pending_results [$];
  int           error_count;
  int           result_count;
  int           rx_count;
  int           tx_count;
  bit           idle_enable;

  task automatic predict_request(input bit kind, input logic [2:0] prio,
                                 input logic [15:0] handle, input logic [6:0] limit);
    logic [15:0] kept [$];
    int          n;
    int          budget;
    int          found;
    int          count;
    spq_result_t r;
    if (kind == REQ_RECEIVE) begin
      level_fifo[prio].push_back(handle);
      n = level_fifo[prio].size();
      if (n > LIMIT) begin
        // keep every second handle counting back from the newest
        for (int i = 0; i < n; i++)
          if (((n - 1 - i) % 2) == 0) kept.push_back(level_fifo[prio][i]);
        level_fifo[prio] = kept;
      end
    end else begin
      budget = (limit > MAX_SEND) ? MAX_SEND : int'(limit);
      count = 0;
      while (count < budget) begin
        found = -1;
        for (int l = LEVELS - 1; l >= 0; l--)
          if (found < 0 && level_fifo[l].size() != 0) found = l;
        if (found < 0) break;
        r.sent = 1'b1;
        r.handle = level_fifo[found].pop_front();
        r.prio = found[2:0];
        r.last = 1'b0;
        pending_results.push_back(r);
        count++;
      end
      if (count == 0) begin
        r = '{sent: 1'b0, handle: '0, prio: '0, last: 1'b1};
        pending_results.push_back(r);
      end else begin
        pending_results[pending_results.size() - 1].last = 1'b1;
      end
    end
  endtask

  // valid stays up after an accept until the next request or an idle gap
  task automatic send_request(input bit kind, input logic [2:0] prio,
                              input logic [15:0] handle, input logic [6:0] limit);
    if (idle_enable && $urandom_range(99) < 38) begin
      in_ch.valid <= 1'b0;
      do @(negedge clk); while (idle_enable && $urandom_range(99) < 38);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= kind;
    in_ch.priority_req <= prio;
    in_ch.packet_handle <= handle;
    in_ch.send_limit <= limit;
    predict_request(kind, prio, handle, limit);
    if (kind == REQ_RECEIVE) rx_count++;
    else tx_count++;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // output stall
  always @(negedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= !(idle_enable && $urandom_range(99) < 38);
  end

  always @(posedge clk) begin
    spq_result_t got;
    spq_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{sent: out_ch.sent, handle: out_ch.out_handle,
              prio: out_ch.out_priority, last: out_ch.last};
      result_count++;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  task automatic test_directed();
    send_request(REQ_SEND, 3'd0, 16'd0, 7'd5);      // empty queues
    send_request(REQ_RECEIVE, 3'd7, 16'hFFFF, 7'h7F);
    send_request(REQ_RECEIVE, 3'd0, 16'h0000, 7'd0);
    send_request(REQ_RECEIVE, 3'd3, 16'hA5A5, 7'd0);
    send_request(REQ_SEND, 3'd7, 16'hFFFF, 7'd0);   // zero limit
    send_request(REQ_SEND, 3'd0, 16'd0, 7'd1);
    send_request(REQ_SEND, 3'd0, 16'd0, 7'h7F);     // limit clipped to max
    for (int i = 0; i < 17; i++)                    // overflow triggers thinning
      send_request(REQ_RECEIVE, 3'd5, 16'h5000 + i[15:0], 7'($urandom));
    send_request(REQ_SEND, 3'd0, 16'd0, 7'd64);
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < 90; i++) begin
      if (i == 50) wait_drained();
      if (i == 20) idle_enable = 1'b0;
      if (i == 45) idle_enable = 1'b1;
      if ($urandom_range(99) < 70)
        send_request(REQ_RECEIVE, 3'($urandom_range(7)), 16'($urandom), 7'($urandom));
      else
        send_request(REQ_SEND, 3'($urandom), 16'($urandom),
                     ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(6)));
    end
  endtask

  task automatic test_flood_thinning();
    // send one level far more handles than its limit
    for (int i = 0; i < 40; i++)
      send_request(REQ_RECEIVE, 3'd2, 16'($urandom), 7'd0);
    send_request(REQ_SEND, 3'd0, 16'd0, 7'd100);
    send_request(REQ_SEND, 3'd0, 16'd0, 7'd64);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_RECEIVE;
    in_ch.priority_req = '0;
    in_ch.packet_handle = '0;
    in_ch.send_limit = '0;
    idle_enable = 1'b1;
    error_count = 0;
    result_count = 0;
    rx_count = 0;
    tx_count = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random_traffic();
    test_flood_thinning();
    wait_drained();
    repeat (50) @(negedge clk);
    $display("covered %0d receive and %0d send requests, %0d results checked",
             rx_count, tx_count, result_count);
    if (error_count == 0 && pending_results.size() == 0)
      $display("strict_priority_packet_queue_top test passed");
    else
      $display("strict_priority_packet_queue_top test failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("strict_priority_packet_queue_top test failed");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/spq_pkg.sv
hw/rtl/spq_if.sv
hw/rtl/spq_ctrl.sv
hw/rtl/spq_datapath.sv
hw/rtl/strict_priority_packet_queue_top.sv
sim/strict_priority_packet_queue_top_test.sv
